// ===== rtl/sktab_pkg.sv =====
package sktab_pkg;

   localparam int TableSizeDefault = 256;
   localparam int NameLenDefault   = 32;
   localparam int HashMult         = 131;

   typedef enum logic [2:0] {
      STAT_FOUND     = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_INSERTED  = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_TOO_LONG  = 3'd4
   } status_type;

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_INSERT = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_REDUCE,
      S_PROBE,
      S_META,
      S_CMP_RD,
      S_CMP_CHK,
      S_COPY_RD,
      S_COPY_WR,
      S_NEXT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] name_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] slot_index;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic meta_we;
      logic meta_valid;
      logic name_we;
   } store_cmd_type;

endpackage

// ===== rtl/string_keyed_hash_table.sv =====
// Timing: a name that is too long answers in the cycle after its last byte; otherwise
//   the hash is first reduced modulo TABLE_SIZE, then probe slots are walked, comparing or copying name bytes.
// Throughput: one name byte per cycle while a name is collected; busy stays high from the
//   last byte until the result strobe, bounded by the probe walk over TABLE_SIZE+1 slots.
// Reset: synchronous; busy holds high while every slot of the table is cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module string_keyed_hash_table #(
   parameter int TABLE_SIZE = sktab_pkg::TableSizeDefault,
   parameter int NAME_LEN   = sktab_pkg::NameLenDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sktab_pkg::req_type req_data,
   output logic               rsp_strobe,
   output sktab_pkg::rsp_type rsp_data
);
   import sktab_pkg::*;

   localparam int IW  = $clog2(TABLE_SIZE);
   localparam int KW  = $clog2(NAME_LEN + 2);
   localparam int KIW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
   localparam int AW  = $clog2(TABLE_SIZE * NAME_LEN);
   localparam int PW  = IW + 2;

   state_type     state_ff, state_in;
   logic [KW-1:0] keylen_ff, keylen_in;
   logic [31:0]   hash_ff, hash_in;
   logic          act_ff, act_in;
   logic          op_ff, op_in;
   logic [KW-1:0] len_ff, len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW:0]   i_ff, i_in;
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] base_ff, base_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [7:0]    slot_ff, slot_in;
   status_type    status_ff, status_in;

   logic [7:0]    key_mem [NAME_LEN];
   logic [7:0]    key_rd_ff;

   logic          accept;
   logic [KW-1:0] keylen_next;
   logic [31:0]   hash_next;
   logic          red_done;
   logic [IW-1:0] red_rem;
   store_cmd_type cmd;
   logic [IW-1:0] slot_addr;
   logic [AW-1:0] name_addr;
   logic          meta_valid;
   logic [KW-1:0] meta_len;
   logic [7:0]    name_rdata;
   logic [IW:0]   i_next;
   logic [PW-1:0] probe_sum;
   logic [IW-1:0] probe_idx;
   logic          last_k;
   logic [31:0]   idx_wide;

   assign accept      = start && !busy;
   assign keylen_next = (keylen_ff <= KW'(NAME_LEN)) ? keylen_ff + KW'(1) : keylen_ff;
   assign hash_next   = (hash_ff << 7) + (hash_ff << 1) + hash_ff + 32'(req_data.name_byte);
   assign i_next      = i_ff + (IW+1)'(1);
   assign probe_sum   = PW'(idx_ff) + (PW'(i_next) << 1) - PW'(1);
   assign probe_idx   = (probe_sum >= PW'(TABLE_SIZE)) ? '0 : probe_sum[IW-1:0];
   assign last_k      = (k_ff == len_ff - KW'(1));
   assign idx_wide    = 32'(idx_ff);

   sktab_reduce #(.TABLE_SIZE(TABLE_SIZE)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .load      (state_ff == S_LOAD),
      .hash      (hash_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   assign slot_addr = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
   assign name_addr = base_ff + AW'(k_ff);

   sktab_store #(.TABLE_SIZE(TABLE_SIZE), .NAME_LEN(NAME_LEN)) u_store (
      .clock      (clock),
      .cmd        (cmd),
      .slot_addr  (slot_addr),
      .meta_wlen  (len_ff),
      .name_addr  (name_addr),
      .name_wdata (key_rd_ff),
      .meta_valid (meta_valid),
      .meta_len   (meta_len),
      .name_rdata (name_rdata)
   );

   // Key buffer
   always_ff @(posedge clock) begin
      if (accept && keylen_ff < KW'(NAME_LEN)) begin
         key_mem[keylen_ff[KIW-1:0]] <= req_data.name_byte;
      end
      key_rd_ff <= key_mem[k_ff[KIW-1:0]];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (clr_ff == IW'(TABLE_SIZE - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept && req_data.last_byte) begin
               state_in = (keylen_next > KW'(NAME_LEN)) ? S_DONE : S_LOAD;
            end
         end
         S_LOAD:    state_in = S_REDUCE;
         S_REDUCE:  if (red_done) state_in = S_PROBE;
         S_PROBE:   state_in = S_META;
         S_META: begin
            if (op_ff == ACT_INSERT) begin
               state_in = meta_valid ? S_NEXT : S_COPY_RD;
            end else begin
               state_in = (meta_valid && meta_len == len_ff) ? S_CMP_RD : S_NEXT;
            end
         end
         S_CMP_RD:  state_in = S_CMP_CHK;
         S_CMP_CHK: begin
            if (name_rdata != key_rd_ff) state_in = S_NEXT;
            else if (last_k)             state_in = S_DONE;
            else                         state_in = S_CMP_RD;
         end
         S_COPY_RD: state_in = S_COPY_WR;
         S_COPY_WR: state_in = last_k ? S_DONE : S_COPY_RD;
         S_NEXT:    state_in = (i_ff == (IW+1)'(TABLE_SIZE)) ? S_DONE : S_PROBE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      busy           = (state_ff != S_IDLE);
      rsp_strobe     = (state_ff == S_DONE);
      rsp_data       = '0;
      rsp_data.slot_index = slot_ff;
      rsp_data.status     = status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.meta_we = 1'b1;
         end
         S_META: begin
            if (op_ff == ACT_INSERT && !meta_valid) begin
               cmd.meta_we    = 1'b1;
               cmd.meta_valid = 1'b1;
            end
         end
         S_COPY_WR: begin
            cmd.name_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      keylen_in = keylen_ff;
      hash_in   = hash_ff;
      act_in    = act_ff;
      op_in     = op_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      base_in   = base_ff;
      clr_in    = clr_ff;
      slot_in   = slot_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_CLEAR: clr_in = clr_ff + IW'(1);
         S_IDLE: begin
            if (accept) begin
               if (keylen_ff == '0) act_in = req_data.action;
               keylen_in = keylen_next;
               hash_in   = hash_next;
               if (req_data.last_byte) begin
                  op_in     = (keylen_ff == '0) ? req_data.action : act_ff;
                  len_in    = keylen_next;
                  keylen_in = '0;
                  act_in    = 1'b0;
                  slot_in   = '0;
                  if (keylen_next > KW'(NAME_LEN)) begin
                     status_in = STAT_TOO_LONG;
                     hash_in   = '0;
                  end
               end
            end
         end
         S_LOAD: begin
            hash_in   = '0;
            status_in = (op_ff == ACT_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
         end
         S_REDUCE: begin
            idx_in = red_rem;
            i_in   = '0;
         end
         S_PROBE: begin
            base_in = AW'(idx_ff) * AW'(NAME_LEN);
            k_in    = '0;
         end
         S_CMP_CHK: begin
            if (name_rdata == key_rd_ff) begin
               if (last_k) begin
                  slot_in   = idx_wide[7:0];
                  status_in = STAT_FOUND;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         S_COPY_WR: begin
            if (last_k) begin
               slot_in   = idx_wide[7:0];
               status_in = STAT_INSERTED;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_NEXT: begin
            if (i_ff != (IW+1)'(TABLE_SIZE)) begin
               idx_in = probe_idx;
               i_in   = i_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         keylen_ff <= '0;
         hash_ff   <= '0;
         act_ff    <= 1'b0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         keylen_ff <= keylen_in;
         hash_ff   <= hash_in;
         act_ff    <= act_in;
         clr_ff    <= clr_in;
      end
      op_ff     <= op_in;
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      base_ff   <= base_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held two cycles");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while accepting requests");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_byte) |=> busy)
      else $error("last byte did not start a search");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STAT_FOUND && rsp_data.status != STAT_INSERTED)
      |-> rsp_data.slot_index == 8'd0) else $error("miss reported a nonzero slot");

endmodule

// ===== rtl/sktab_reduce.sv =====
module sktab_reduce #(
   parameter int TABLE_SIZE = sktab_pkg::TableSizeDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [31:0]                        hash,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      remainder
);
   import sktab_pkg::*;

   localparam int          IW      = $clog2(TABLE_SIZE);
   localparam int          Shift   = 31 + IW;
   localparam logic [63:0] Recip   = (64'd1 << Shift) / 64'(TABLE_SIZE);
   localparam logic [31:0] RecipLo = Recip[31:0];

   logic [31:0]   mag_ff, mag_in;
   logic [63:0]   prod_ff, prod_in;
   logic [31:0]   qt_ff, qt_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic [2:0]    stage_ff, stage_in;
   logic          done_ff, done_in;
   logic [31:0]   quot;
   logic [31:0]   diff;

   // Reciprocal multiplication: the quotient estimate is exact or one low,
   // so one compare and subtract finishes the remainder
   always_comb begin
      mag_in   = load ? (hash[31] ? (32'd0 - hash) : hash) : mag_ff;
      stage_in = {stage_ff[1:0], load};
      prod_in  = 64'(mag_ff) * 64'(RecipLo);
      quot     = 32'(prod_ff >> Shift);
      qt_in    = quot * 32'(TABLE_SIZE);
      diff     = mag_ff - qt_ff;
      rem_in   = rem_ff;
      if (stage_ff[2]) begin
         rem_in = (diff >= 32'(TABLE_SIZE)) ? IW'(diff - 32'(TABLE_SIZE)) : IW'(diff);
      end
      done_in  = stage_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      qt_ff   <= qt_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/sktab_store.sv =====
module sktab_store #(
   parameter int TABLE_SIZE = sktab_pkg::TableSizeDefault,
   parameter int NAME_LEN   = sktab_pkg::NameLenDefault
) (
   input  logic                                      clock,
   input  sktab_pkg::store_cmd_type                  cmd,
   input  logic [$clog2(TABLE_SIZE)-1:0]             slot_addr,
   input  logic [$clog2(NAME_LEN+2)-1:0]             meta_wlen,
   input  logic [$clog2(TABLE_SIZE*NAME_LEN)-1:0]    name_addr,
   input  logic [7:0]                                name_wdata,
   output logic                                      meta_valid,
   output logic [$clog2(NAME_LEN+2)-1:0]             meta_len,
   output logic [7:0]                                name_rdata
);
   import sktab_pkg::*;

   localparam int KW    = $clog2(NAME_LEN + 2);
   localparam int Depth = TABLE_SIZE * NAME_LEN;

   logic [KW:0] meta_mem [TABLE_SIZE];
   logic [7:0]  name_mem [Depth];
   logic [KW:0] meta_rd_ff;
   logic [7:0]  name_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.meta_we) begin
         meta_mem[slot_addr] <= {cmd.meta_valid, meta_wlen};
      end
      meta_rd_ff <= meta_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.name_we) begin
         name_mem[name_addr] <= name_wdata;
      end
      name_rd_ff <= name_mem[name_addr];
   end

   assign meta_valid = meta_rd_ff[KW];
   assign meta_len   = meta_rd_ff[KW-1:0];
   assign name_rdata = name_rd_ff;

endmodule
